>>> hw/rtl/psdes_pkg.sv
`default_nettype none
package psdes_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned HALF_W  = 16;
  localparam int unsigned ROUND_W = 2;
  localparam int unsigned FRAC_SHIFT = 9;

  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [HALF_W-1:0]  half_t;
  typedef logic [ROUND_W-1:0] round_t;

  typedef enum logic [1:0] {
    OP_RAW   = 2'd0,
    OP_FRAC  = 2'd1,
    OP_BOUND = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_ROUND = 2'd1,
    ST_FMT   = 2'd2
  } state_t;

  localparam round_t LAST_ROUND = 2'd3;

  // Seed register indexes.
  localparam logic CFG_SEED_LOW  = 1'b0;
  localparam logic CFG_SEED_HIGH = 1'b1;

  function automatic word_t key_a(input round_t r);
    word_t k;
    case (r)
      2'd0:    k = 32'hBAA96887;
      2'd1:    k = 32'h1E17D32C;
      2'd2:    k = 32'h03BCDC3C;
      default: k = 32'h0F33D1B2;
    endcase
    return k;
  endfunction

  function automatic word_t key_b(input round_t r);
    word_t k;
    case (r)
      2'd0:    k = 32'h4B0F3B58;
      2'd1:    k = 32'hE874F0C3;
      2'd2:    k = 32'h6955C5A6;
      default: k = 32'h55A7CA46;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/psdes_round.sv
`default_nettype none
module psdes_round
  import psdes_pkg::*;
(
  input  wire word_t  left,
  input  wire word_t  right,
  input  wire round_t rnd,
  output word_t       next
);

  word_t a;
  half_t lo;
  half_t hi;
  word_t sq_lo;
  word_t sq_hi;
  word_t prod;
  word_t b;
  word_t sw;

  always_comb begin
    a     = right ^ key_a(rnd);
    lo    = a[HALF_W-1:0];
    hi    = a[WORD_W-1:HALF_W];
    sq_lo = word_t'(lo) * word_t'(lo);
    sq_hi = word_t'(hi) * word_t'(hi);
    prod  = word_t'(lo) * word_t'(hi);
    b     = sq_lo + ~sq_hi;
    // swap halves
    sw    = {b[HALF_W-1:0], b[WORD_W-1:HALF_W]};
    next  = left ^ ((sw ^ key_b(rnd)) + prod);
  end

endmodule
`default_nettype wire

>>> hw/rtl/psdes_fmt.sv
`default_nettype none
module psdes_fmt
  import psdes_pkg::*;
(
  input  wire word_t   w,
  input  wire opcode_t op,
  input  wire half_t   bound,
  output word_t        value
);

  word_t             p_lo;
  word_t             p_hi;
  logic [WORD_W:0]   acc;

  always_comb begin
    p_lo = word_t'(w[HALF_W-1:0]) * word_t'(bound);
    p_hi = word_t'(w[WORD_W-1:HALF_W]) * word_t'(bound);
    acc  = {{(HALF_W+1){1'b0}}, p_lo[WORD_W-1:HALF_W]} + {1'b0, p_hi};
    case (op)
      OP_FRAC:  value = {{FRAC_SHIFT{1'b0}}, w[WORD_W-1:FRAC_SHIFT+1], 1'b1};
      OP_BOUND: value = {{HALF_W{1'b0}}, acc[WORD_W-1:HALF_W]};
      default:  value = w;
    endcase
  end

endmodule
`default_nettype wire

>>> hw/rtl/psdes_counter_random_generator.sv
// Counter-based pseudo-DES random generator.
// Input channel (in_valid/in_ready): one beat carries an opcode and a bound.
//   Opcode raw returns the 32-bit hash word, opcode fraction returns
//   (word >> 9) | 1 as a Q0.23 fraction, opcode bound returns an integer
//   below the 16-bit bound (zero for a zero bound). The unused fourth
//   opcode returns the raw word.
// Output channel (out_valid/out_ready): one beat with out_value per request.
// Configuration: cfg_wr_en with cfg_addr selects seed low (index 0) or seed
//   high (index 1); either write reloads the 64-bit counter from both seeds.
//   Write only while no request is in flight.
// Sequence: the shared round unit runs the four mixing rounds one per cycle,
//   then the scaling step formats the word into the output register;
//   in_ready rises again at the edge that loads the result.
// Occupancy: a new request is accepted only after the last one's result is loaded.
// Stall: the output register holds the result while out_ready is low; a new
//   request is still accepted and hashed, and waits in the scaling step until
//   the output register is free.
// Reset (rst_n low, synchronous): seeds and counter clear to zero, the
//   sequencer returns to idle and no result beat is pending.
`default_nettype none
module psdes_counter_random_generator
  import psdes_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [1:0]  in_opcode,
  input  wire  [15:0] in_bound,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [31:0] out_value,
  input  wire         cfg_wr_en,
  input  wire         cfg_addr,
  input  wire  [31:0] cfg_wdata
);

  state_t  state_r, state_nxt;
  round_t  rnd_r, rnd_nxt;
  word_t   seed_lo_r, seed_hi_r;
  word_t   cnt_lo_r, cnt_hi_r;
  word_t   cnt_lo_nxt, cnt_hi_nxt;
  word_t   left_r, left_nxt;
  word_t   right_r, right_nxt;
  opcode_t op_r;
  half_t   bound_r;
  word_t   out_value_r;
  logic    out_valid_r, out_valid_nxt;
  logic    load_out;
  logic    accept;
  word_t   round_out;
  word_t   fmt_value;

  psdes_round u_round (
    .left  (left_r),
    .right (right_r),
    .rnd   (rnd_r),
    .next  (round_out)
  );

  psdes_fmt u_fmt (
    .w     (right_r),
    .op    (op_r),
    .bound (bound_r),
    .value (fmt_value)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

  // Sequencer: load the counter, run four rounds, then scale into the output.
  always_comb begin
    state_nxt     = state_r;
    rnd_nxt       = rnd_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    load_out      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          left_nxt  = cnt_hi_r;
          right_nxt = cnt_lo_r;
          rnd_nxt   = '0;
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        left_nxt  = right_r;
        right_nxt = round_out;
        rnd_nxt   = rnd_r + round_t'(1);
        if (rnd_r == LAST_ROUND) begin
          state_nxt = ST_FMT;
        end
      end
      ST_FMT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Counter: advance once per accepted request, carry low into high;
  // a seed write reloads both words.
  always_comb begin
    cnt_lo_nxt = cnt_lo_r;
    cnt_hi_nxt = cnt_hi_r;
    if (cfg_wr_en) begin
      cnt_hi_nxt = (cfg_addr == CFG_SEED_LOW)  ? cfg_wdata : seed_lo_r;
      cnt_lo_nxt = (cfg_addr == CFG_SEED_HIGH) ? cfg_wdata : seed_hi_r;
    end else if (accept) begin
      cnt_lo_nxt = cnt_lo_r + word_t'(1);
      if (cnt_lo_r == '1) begin
        cnt_hi_nxt = cnt_hi_r + word_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rnd_r       <= '0;
      out_valid_r <= 1'b0;
      seed_lo_r   <= '0;
      seed_hi_r   <= '0;
      cnt_lo_r    <= '0;
      cnt_hi_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      rnd_r       <= rnd_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_lo_r    <= cnt_lo_nxt;
      cnt_hi_r    <= cnt_hi_nxt;
      if (cfg_wr_en && (cfg_addr == CFG_SEED_LOW)) begin
        seed_lo_r <= cfg_wdata;
      end
      if (cfg_wr_en && (cfg_addr == CFG_SEED_HIGH)) begin
        seed_hi_r <= cfg_wdata;
      end
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk) begin
    left_r  <= left_nxt;
    right_r <= right_nxt;
    if (accept) begin
      op_r    <= opcode_t'(in_opcode);
      bound_r <= in_bound;
    end
    if (load_out) begin
      out_value_r <= fmt_value;
    end
  end

endmodule
`default_nettype wire

>>> tb/psdes_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module psdes_checker
  import psdes_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  input  wire         in_ready,
  input  wire  [1:0]  in_opcode,
  input  wire  [15:0] in_bound,
  input  wire         out_valid,
  input  wire         out_ready,
  input  wire  [31:0] out_value,
  input  wire         cfg_wr_en,
  input  wire         cfg_addr,
  input  wire  [31:0] cfg_wdata,
  output int unsigned errors,
  output int unsigned pending,
  output int unsigned matched
);

  localparam int unsigned REPORT_MAX = 10;

  // Per-round key words, round 0 in the low 32 bits.
  localparam logic [127:0] WHITEN_KEYS =
    {32'h0F33D1B2, 32'h03BCDC3C, 32'h1E17D32C, 32'hBAA96887};
  localparam logic [127:0] SWAP_KEYS =
    {32'h55A7CA46, 32'h6955C5A6, 32'hE874F0C3, 32'h4B0F3B58};

  word_t seed_low;
  word_t seed_high;
  word_t count_low;
  word_t count_high;
  word_t expected_values[$];

  function automatic word_t psdes_round(input word_t x, input int unsigned r);
    word_t a;
    word_t lo;
    word_t hi;
    word_t b;
    word_t sw;
    a  = x ^ WHITEN_KEYS[r*32 +: 32];
    lo = {16'h0000, a[15:0]};
    hi = {16'h0000, a[31:16]};
    b  = lo * lo + ~(hi * hi);
    sw = {b[15:0], b[31:16]};
    return (sw ^ SWAP_KEYS[r*32 +: 32]) + lo * hi;
  endfunction

  function automatic word_t psdes_hash(input word_t upper, input word_t lower);
    word_t l;
    word_t r;
    word_t nxt;
    l = upper;
    r = lower;
    for (int unsigned i = 0; i < 4; i++) begin
      nxt = l ^ psdes_round(r, i);
      l   = r;
      r   = nxt;
    end
    return r;
  endfunction

  function automatic word_t format_draw(input logic [1:0] op, input half_t bnd,
                                        input word_t w);
    logic [63:0] acc;
    word_t       v;
    case (op)
      OP_FRAC: v = (w >> FRAC_SHIFT) | 32'd1;
      OP_BOUND: begin
        acc = ((64'(w[15:0]) * 64'(bnd)) >> 16) + 64'(w[31:16]) * 64'(bnd);
        v   = {16'h0000, acc[31:16]};
      end
      default: v = w;
    endcase
    return v;
  endfunction

  always @(posedge clk) begin : watch
    word_t want;
    if (!rst_n) begin
      seed_low   = '0;
      seed_high  = '0;
      count_low  = '0;
      count_high = '0;
      expected_values.delete();
      errors  = 0;
      matched = 0;
    end else begin
      // Results first: an expectation is always older than this edge's request.
      if (out_valid && out_ready) begin
        if (expected_values.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("[%0t] result beat with nothing expected: value=%08h",
                     $time, out_value);
        end else begin
          want = expected_values.pop_front();
          if (out_value !== want) begin
            errors++;
            if (errors <= REPORT_MAX)
              $display("[%0t] value mismatch: expected=%08h actual=%08h",
                       $time, want, out_value);
          end else begin
            matched++;
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_values.insert(expected_values.size(),
                               format_draw(in_opcode, in_bound,
                                           psdes_hash(count_high, count_low)));
        count_low = count_low + 32'd1;
        if (count_low == '0)
          count_high = count_high + 32'd1;
      end
      if (cfg_wr_en) begin
        if (cfg_addr == CFG_SEED_LOW)
          seed_low = cfg_wdata;
        else
          seed_high = cfg_wdata;
        count_high = seed_low;
        count_low  = seed_high;
      end
    end
    pending = expected_values.size();
  end

endmodule
`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import psdes_pkg::*;

  // Unnamed fourth opcode; the block treats it as a raw draw.
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam int unsigned PIPE_LATENCY = 6;
  localparam int unsigned PHASE_ITEMS  = 317;
  localparam int unsigned BACKLOG_HOLD = 80;
  localparam int unsigned QUIET_LIMIT  = 2000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_opcode;
  logic [15:0] in_bound;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_value;
  logic        cfg_wr_en;
  logic        cfg_addr;
  logic [31:0] cfg_wdata;

  int unsigned chk_errors;
  int unsigned chk_pending;
  int unsigned chk_matched;

  int unsigned items_sent;
  int unsigned beats_drained;
  int unsigned seed_settings;
  int unsigned op_seen[4];
  int unsigned quiet_cycles;

  psdes_counter_random_generator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .in_bound  (in_bound),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_value (out_value),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  psdes_checker i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .in_bound  (in_bound),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_value (out_value),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .errors    (chk_errors),
    .pending   (chk_pending),
    .matched   (chk_matched)
  );

  // 4 ns clock.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Watchdog: end the run if no beat moves on either channel for too long.
  // The longest legal quiet spell is the backlog hold plus a few gaps.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, chk_pending);
      $display("[psdes_counter_random_generator] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: draw a stall before every beat, then hold ready until the beat
  // is taken. Twice in the run, hold off long enough for the block to back up
  // and drop in_ready while the sender keeps offering. Every fourth stretch
  // of 128 beats runs with ready held high, except where the first hold falls.
  initial begin : drain
    int unsigned stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (beats_drained == 300 || beats_drained == 1200)
        stall = BACKLOG_HOLD;
      else if (((beats_drained / 128) % 4) == 2)
        stall = 0;
      else
        stall = $urandom_range(0, 10);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      beats_drained++;
      @(negedge clk);
    end
  end

  // Offer one request beat. Entered and left on a falling edge; valid stays
  // high on return so a back-to-back beat does not drop it in between.
  task automatic send_beat(input logic [1:0] op, input half_t bnd);
    int unsigned gap;
    gap = (((items_sent / 128) % 4) == 1) ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_bound  <= bnd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    op_seen[op]++;
    @(negedge clk);
  endtask

  // Random request: mostly raw, fraction and bounded draws, with the spare
  // opcode now and then and bounds biased towards zero, small values and full scale.
  task automatic send_random();
    int unsigned pick;
    logic [1:0]  op;
    half_t       bnd;
    pick = $urandom_range(0, 15);
    if (pick == 0)
      op = OP_SPARE;
    else if (pick <= 5)
      op = OP_RAW;
    else if (pick <= 10)
      op = OP_FRAC;
    else
      op = OP_BOUND;
    case ($urandom_range(0, 9))
      0:       bnd = 16'h0000;
      1:       bnd = 16'hFFFF;
      2:       bnd = 16'($urandom_range(1, 15));
      default: bnd = 16'($urandom_range(0, 65535));
    endcase
    send_beat(op, bnd);
  endtask

  // Drop valid and wait until every result is back and the pipe has drained.
  task automatic settle();
    in_valid <= 1'b0;
    while (chk_pending != 0) @(negedge clk);
    repeat (PIPE_LATENCY + 2) @(negedge clk);
  endtask

  // One register write; the caller marks the last of a group so the enable
  // is lowered only once.
  task automatic write_seed(input logic idx, input word_t data, input bit last);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    if (last)
      cfg_wr_en <= 1'b0;
  endtask

  initial begin : stimulus
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_opcode = OP_RAW;
    in_bound  = '0;
    cfg_wr_en = 1'b0;
    cfg_addr  = CFG_SEED_LOW;
    cfg_wdata = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: every opcode from the reset counter, bound extremes and the
    // zero bound, the spare opcode.
    send_beat(OP_RAW,   16'h0000);
    send_beat(OP_FRAC,  16'hFFFF);
    send_beat(OP_BOUND, 16'h0000);
    send_beat(OP_BOUND, 16'h0001);
    send_beat(OP_BOUND, 16'hFFFF);
    send_beat(OP_BOUND, 16'h8000);
    send_beat(OP_BOUND, 16'h5555);
    send_beat(OP_BOUND, 16'hAAAA);
    send_beat(OP_SPARE, 16'h1234);
    send_beat(OP_FRAC,  16'h0000);

    // Park the counter one below the top of its 64-bit range: the low word
    // carries into the high word, which wraps to zero without a flag.
    settle();
    write_seed(CFG_SEED_LOW,  32'hFFFF_FFFF, 1'b0);
    write_seed(CFG_SEED_HIGH, 32'hFFFF_FFFE, 1'b1);
    seed_settings++;
    send_beat(OP_RAW,   16'h0000);
    send_beat(OP_FRAC,  16'h0000);
    send_beat(OP_BOUND, 16'hFFFF);
    send_beat(OP_SPARE, 16'hFFFF);
    send_beat(OP_RAW,   16'h0000);

    // A write to one register reloads both counter words.
    settle();
    write_seed(CFG_SEED_LOW, 32'h0000_0000, 1'b1);
    seed_settings++;
    send_beat(OP_RAW,   16'h0000);
    send_beat(OP_BOUND, 16'h0100);
    send_beat(OP_FRAC,  16'h0000);

    // Random phases, each under a fresh seed setting: zeros, a low-word
    // carry mid-phase, a full 64-bit wrap mid-phase, random seeds and
    // single-register reloads.
    for (int unsigned p = 0; p < 6; p++) begin
      settle();
      case (p)
        0: begin
          write_seed(CFG_SEED_LOW,  32'h0000_0000, 1'b0);
          write_seed(CFG_SEED_HIGH, 32'h0000_0000, 1'b1);
        end
        1: begin
          write_seed(CFG_SEED_LOW,  $urandom(), 1'b0);
          write_seed(CFG_SEED_HIGH, 32'hFFFF_FFFF - 32'd100, 1'b1);
        end
        2: write_seed(CFG_SEED_HIGH, $urandom(), 1'b1);
        3: begin
          write_seed(CFG_SEED_LOW,  32'hFFFF_FFFF, 1'b0);
          write_seed(CFG_SEED_HIGH, 32'hFFFF_FFFF - 32'd150, 1'b1);
        end
        4: begin
          write_seed(CFG_SEED_LOW,  $urandom(), 1'b0);
          write_seed(CFG_SEED_HIGH, $urandom(), 1'b1);
        end
        default: write_seed(CFG_SEED_LOW, $urandom(), 1'b1);
      endcase
      seed_settings++;
      repeat (PHASE_ITEMS) send_random();
    end

    settle();
    $display("run covered %0d requests: raw %0d, fraction %0d, bounded %0d, spare %0d",
             items_sent, op_seen[OP_RAW], op_seen[OP_FRAC], op_seen[OP_BOUND],
             op_seen[OP_SPARE]);
    $display("%0d seed settings incl. carry and 64-bit wrap; %0d matched, %0d failed",
             seed_settings, chk_matched, chk_errors);
    if (chk_errors == 0 && chk_pending == 0) begin
      $display("[psdes_counter_random_generator] OK");
    end else begin
      $display("[psdes_counter_random_generator] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
